// ===== rtl/core/mre_pkg.sv =====
// mre_pkg: shared types and constants for the r-type execute block
// no dependencies
package mre_pkg;

  localparam logic [4:0]  LINK_REG = 5'd31;
  localparam logic [31:0] PC_STEP  = 32'h0000_0004;

  typedef enum logic [4:0] {
    K_ADD = 5'd0, K_ADDU = 5'd1, K_SUB = 5'd2, K_SUBU = 5'd3,
    K_MULT = 5'd4, K_MULTU = 5'd5, K_DIV = 5'd6, K_DIVU = 5'd7,
    K_AND = 5'd8, K_NOR = 5'd9, K_OR = 5'd10, K_XOR = 5'd11,
    K_SLL = 5'd12, K_SLLV = 5'd13, K_SRL = 5'd14, K_SRA = 5'd15,
    K_SRLV = 5'd16, K_SRAV = 5'd17, K_SLT = 5'd18, K_SLTU = 5'd19,
    K_JR = 5'd20, K_JALR = 5'd21, K_MFHI = 5'd22, K_MFLO = 5'd23
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item, start reading operands
    logic rd_op;     // operands at ram outputs, latch them
    logic exec;      // register alu results, start mul/div
    logic step;      // one iteration of mul/div
    logic finish;    // commit writeback and result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iter_op;   // current item needs the iterative unit
    logic iter_done; // current step is the last iteration
  } sts_t;

endpackage

// ===== rtl/core/mre_ram.sv =====
// mre_ram: generic single write, single read ram with registered read
// no dependencies
module mre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/mre_ctrl.sv =====
// mre_ctrl: sequencing state machine for the r-type execute block
// depends on mre_pkg
module mre_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_free,
  input  mre_pkg::sts_t  sts,
  output logic           busy,
  output mre_pkg::cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_FIN} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_nxt = S_RD1; end
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  begin cmd.rd_op = 1'b1; state_nxt = S_EXEC; end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.iter_op ? S_ITER : S_FIN;
      end
      S_ITER: begin
        cmd.step = 1'b1;
        if (sts.iter_done) state_nxt = S_FIN;
      end
      S_FIN:  if (out_free) begin cmd.finish = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ===== rtl/core/mre_dp.sv =====
// mre_dp: register file, hi/lo, alu and shift-add / restoring divide unit
// depends on mre_pkg, mre_ram
module mre_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  mre_pkg::cmd_t cmd,
  output mre_pkg::sts_t sts,
  input  logic [4:0]    kind,
  input  logic [31:0]   instr_word,
  input  logic [31:0]   cur_pc,
  output logic [135:0]  res   // packed result fields, lowest first
);
  logic [4:0]  kind_r, rs_r, rt_r, rd_r, sa_r;
  logic [31:0] pc_r, a_r, b_r, hi_r, lo_r;
  logic [31:0] a_ram, b_ram;
  // valid bits: rf entry written since reset
  logic [31:0] vld_r;
  logic        wr_r, jmp_r, dz_r;
  logic [4:0]  dst_r;
  logic [31:0] val_r, npc_r;
  // iterative unit
  logic [63:0] acc_r;
  logic [31:0] opb_r;
  logic [5:0]  cnt_r;
  logic        neg_q_r, neg_r_r;
  logic [33:0] trial;
  logic [32:0] psum;
  logic [31:0] ma, mb;
  logic        na, nb, is_mul, is_sgn;
  logic [31:0] alu;
  logic        alu_wr;
  logic [4:0]  shv;
  logic [63:0] prod;
  logic        rf_we;

  mre_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
    .clk, .we(rf_we), .waddr(dst_r), .wdata(val_r),
    .raddr(rs_r), .rdata(a_ram));
  mre_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
    .clk, .we(rf_we), .waddr(dst_r), .wdata(val_r),
    .raddr(rt_r), .rdata(b_ram));

  assign rf_we = cmd.finish && wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (rf_we) vld_r[dst_r] <= 1'b1;
  end

  assign is_mul = (kind_r == mre_pkg::K_MULT) || (kind_r == mre_pkg::K_MULTU);
  assign is_sgn = (kind_r == mre_pkg::K_MULT) || (kind_r == mre_pkg::K_DIV);
  assign na = is_sgn && a_r[31];
  assign nb = is_sgn && b_r[31];
  assign ma = na ? 32'd0 - a_r : a_r;
  assign mb = nb ? 32'd0 - b_r : b_r;
  assign sts.iter_op = is_mul || (kind_r == mre_pkg::K_DIV) || (kind_r == mre_pkg::K_DIVU);
  assign sts.iter_done = (cnt_r == 6'd1);
  // partial remainder shifted left with the next dividend bit, minus divisor
  assign trial = {1'b0, acc_r[63:31]} - {2'b0, opb_r};
  // high half plus multiplicand, carry kept
  assign psum = {1'b0, acc_r[63:32]} + {1'b0, (acc_r[0] ? opb_r : 32'd0)};

  always_comb begin
    shv = ((kind_r == mre_pkg::K_SLLV) || (kind_r == mre_pkg::K_SRLV) ||
           (kind_r == mre_pkg::K_SRAV)) ? a_r[4:0] : sa_r;
    alu = '0;
    alu_wr = 1'b1;
    case (kind_r)
      mre_pkg::K_ADD, mre_pkg::K_ADDU: alu = a_r + b_r;
      mre_pkg::K_SUB, mre_pkg::K_SUBU: alu = a_r - b_r;
      mre_pkg::K_AND:  alu = a_r & b_r;
      mre_pkg::K_NOR:  alu = ~(a_r | b_r);
      mre_pkg::K_OR:   alu = a_r | b_r;
      mre_pkg::K_XOR:  alu = a_r ^ b_r;
      mre_pkg::K_SLL, mre_pkg::K_SLLV: alu = b_r << shv;
      mre_pkg::K_SRL, mre_pkg::K_SRLV: alu = b_r >> shv;
      mre_pkg::K_SRA, mre_pkg::K_SRAV: alu = $unsigned($signed(b_r) >>> shv);
      mre_pkg::K_SLT:  alu = {31'd0, $signed(a_r) < $signed(b_r)};
      mre_pkg::K_SLTU: alu = {31'd0, a_r < b_r};
      mre_pkg::K_JALR: alu = pc_r + mre_pkg::PC_STEP;
      mre_pkg::K_MFHI: alu = hi_r;
      mre_pkg::K_MFLO: alu = lo_r;
      default: alu_wr = 1'b0;
    endcase
  end

  assign prod = is_mul ? acc_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.exec) begin
        cnt_r <= 6'd32;
        opb_r <= is_mul ? ma : mb;
        acc_r <= {32'd0, is_mul ? mb : ma};
        neg_q_r <= na ^ nb;
        neg_r_r <= na;
        dz_r <= !is_mul && sts.iter_op && (b_r == 32'd0);
        jmp_r <= (kind_r == mre_pkg::K_JR) || (kind_r == mre_pkg::K_JALR);
        npc_r <= ((kind_r == mre_pkg::K_JR) || (kind_r == mre_pkg::K_JALR)) ? a_r : '0;
        dst_r <= (kind_r == mre_pkg::K_JALR) ? mre_pkg::LINK_REG : rd_r;
        wr_r <= alu_wr && !sts.iter_op && (kind_r != mre_pkg::K_JR) &&
                ((kind_r == mre_pkg::K_JALR) || (rd_r != 5'd0));
        val_r <= alu;
      end
      if (cmd.step) begin
        cnt_r <= cnt_r - 6'd1;
        if (is_mul) begin
          // shift-add: multiplier in low half, product accumulates high
          acc_r <= {psum, acc_r[31:1]};
        end else if (!trial[33]) begin
          acc_r <= {trial[31:0], acc_r[30:0], 1'b1};
        end else begin
          acc_r <= {acc_r[62:0], 1'b0};
        end
      end
      if (cmd.finish && sts.iter_op && !dz_r) begin
        if (is_mul) begin
          {hi_r, lo_r} <= (neg_q_r ? 64'd0 - acc_r : acc_r);
        end else begin
          lo_r <= neg_q_r ? 32'd0 - acc_r[31:0] : acc_r[31:0];
          hi_r <= neg_r_r ? 32'd0 - acc_r[63:32] : acc_r[63:32];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      rs_r <= instr_word[25:21];
      rt_r <= instr_word[20:16];
      rd_r <= instr_word[15:11];
      sa_r <= instr_word[10:6];
      pc_r <= cur_pc;
    end
    if (cmd.rd_op) begin
      a_r <= vld_r[rs_r] ? a_ram : '0;
      b_r <= vld_r[rt_r] ? b_ram : '0;
    end
  end

  // result fields; hi/lo shown as after this step
  logic [63:0] hl_new;
  always_comb begin
    hl_new = {hi_r, lo_r};
    if (sts.iter_op && !dz_r) begin
      if (is_mul) hl_new = neg_q_r ? 64'd0 - prod : prod;
      else hl_new = {neg_r_r ? 32'd0 - acc_r[63:32] : acc_r[63:32],
                     neg_q_r ? 32'd0 - acc_r[31:0] : acc_r[31:0]};
    end
  end

  assign res = {dz_r, npc_r, jmp_r, hl_new[31:0], hl_new[63:32],
                wr_r ? val_r : 32'd0, wr_r ? dst_r : 5'd0, wr_r};
endmodule

// ===== rtl/core/mips_rtype_execute.sv =====
// mips_rtype_execute: top level of the r-type execute block
// depends on mre_pkg, mre_ctrl, mre_dp
//
// input channel in_*: one beat per instruction (kind, instruction word, pc)
// output channel out_*: one beat per instruction with the write, hi, lo,
//   jump and divide-by-zero results
// the register file is two ram copies of 32 entries, one per read port, with a
//   valid bit per entry, so reset clears it at once with no clearing pass
// each instruction passes the states rd1, rd2, exec and fin; mult, multu, div
//   and divu also pass the iter state, where the shift-add / restoring
//   divide unit takes one bit per cycle and sets the rate
// one instruction is in flight at a time; in_tready is low from the
//   accepted beat until the result beat has been loaded into the output
//   register
// the output register holds the result while out_tready is low; the next
//   input beat is taken as soon as the result is registered
// reset (rst_n low, synchronous) empties the output register, zeroes hi,
//   lo and the register file
module mips_rtype_execute (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [4:0]   in_tuser,   // kind
  input  logic [63:0]  in_tdata,   // instr_word[31:0], cur_pc[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // reg_written, dest_reg, dest_value, hi_value,
                                   // lo_value, jump_taken, next_pc,
                                   // divide_by_zero
);
  mre_pkg::cmd_t cmd;
  mre_pkg::sts_t sts;
  logic          busy, in_fire, out_free;
  logic [135:0]  res;
  logic          ovalid_r;
  logic [135:0]  odata_r;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;

  mre_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_free, .sts, .busy, .cmd);

  mre_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .kind(in_tuser),
    .instr_word(in_tdata[31:0]), .cur_pc(in_tdata[63:32]), .res);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.finish) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) odata_r <= res;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

// ===== rtl/core/mre_chk.sv =====
// mre_chk: port-level checker for mips_rtype_execute, bound to the top level
// depends on mips_rtype_execute
module mre_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed under stall");
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");
  a_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[5:1] != 5'd0)
    else $error("write reported to register zero");
  a_no_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[37:1] == 37'd0)
    else $error("stale dest fields without write");
endmodule

bind mips_rtype_execute mre_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata);

// ===== dv/tb_mips_rtype_execute.sv =====
// tb_mips_rtype_execute: self-checking bench for the r-type execute block
// depends on mre_pkg and mips_rtype_execute; has its own register file / hi / lo model
`timescale 1ns / 1ps

module tb_mips_rtype_execute;

  typedef struct packed {
    logic        dz;
    logic [31:0] npc;
    logic        jmp;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] val;
    logic [4:0]  dst;
    logic        wr;
  } exec_res_t;  // fields listed msb first, same layout as on out_tdata

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] iw;
    logic [31:0] pc;
    bit          typed;
    exec_res_t   res;
  } stim_row_t;

  localparam int LIMIT = 600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [4:0]   in_tuser = '0;   // kind
  logic [63:0]  in_tdata = '0;   // instr_word, cur_pc
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;       // reg_written, dest_reg, dest_value, hi, lo, jump, next_pc, dz

  mips_rtype_execute i_dut (.*);

  always #10 clk = ~clk;

  // model state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  exec_res_t   pending_q[$];
  bit          typed_q[$];
  exec_res_t   typed_res_q[$];
  int          errors = 0;
  int          cycle = 0;
  bit          quiet = 1'b0;

  function automatic logic [31:0] shr_arith(logic [31:0] x, logic [4:0] sh);
    return $unsigned($signed(x) >>> sh);
  endfunction

  // executes one instruction on the model state, returns the beat it must produce
  function automatic exec_res_t execute(logic [4:0] kind, logic [31:0] iw, logic [31:0] pc);
    exec_res_t   r;
    logic [31:0] a, b, ma, mb, q, rm;
    logic [63:0] p;
    logic        na, nb;
    logic [4:0]  sa;
    r = '0;
    a = gpr[iw[25:21]];
    b = gpr[iw[20:16]];
    r.dst = iw[15:11];
    sa = iw[10:6];
    case (kind)
      mre_pkg::K_ADD, mre_pkg::K_ADDU: begin r.wr = 1; r.val = a + b; end
      mre_pkg::K_SUB, mre_pkg::K_SUBU: begin r.wr = 1; r.val = a - b; end
      mre_pkg::K_MULT: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        {hi_q, lo_q} = p;
      end
      mre_pkg::K_MULTU: begin p = {32'b0, a} * {32'b0, b}; {hi_q, lo_q} = p; end
      mre_pkg::K_DIV: begin
        if (b == 0) r.dz = 1;
        else begin
          na = a[31]; nb = b[31];
          ma = na ? -a : a;
          mb = nb ? -b : b;
          q = ma / mb; rm = ma % mb;
          lo_q = (na != nb) ? -q : q;
          hi_q = na ? -rm : rm;
        end
      end
      mre_pkg::K_DIVU: begin
        if (b == 0) r.dz = 1;
        else begin lo_q = a / b; hi_q = a % b; end
      end
      mre_pkg::K_AND:  begin r.wr = 1; r.val = a & b; end
      mre_pkg::K_NOR:  begin r.wr = 1; r.val = ~(a | b); end
      mre_pkg::K_OR:   begin r.wr = 1; r.val = a | b; end
      mre_pkg::K_XOR:  begin r.wr = 1; r.val = a ^ b; end
      mre_pkg::K_SLL:  begin r.wr = 1; r.val = b << sa; end
      mre_pkg::K_SLLV: begin r.wr = 1; r.val = b << a[4:0]; end
      mre_pkg::K_SRL:  begin r.wr = 1; r.val = b >> sa; end
      mre_pkg::K_SRA:  begin r.wr = 1; r.val = shr_arith(b, sa); end
      mre_pkg::K_SRLV: begin r.wr = 1; r.val = b >> a[4:0]; end
      mre_pkg::K_SRAV: begin r.wr = 1; r.val = shr_arith(b, a[4:0]); end
      mre_pkg::K_SLT:  begin r.wr = 1; r.val = {31'b0, $signed(a) < $signed(b)}; end
      mre_pkg::K_SLTU: begin r.wr = 1; r.val = {31'b0, a < b}; end
      mre_pkg::K_JR:   begin r.jmp = 1; r.npc = a; end
      mre_pkg::K_JALR: begin
        r.jmp = 1; r.npc = a; r.wr = 1; r.dst = mre_pkg::LINK_REG;
        r.val = pc + mre_pkg::PC_STEP;
      end
      mre_pkg::K_MFHI: begin r.wr = 1; r.val = hi_q; end
      mre_pkg::K_MFLO: begin r.wr = 1; r.val = lo_q; end
      default: ;  // unused kinds change nothing
    endcase
    if (r.wr && r.dst == 0) r.wr = 0;
    if (r.wr) gpr[r.dst] = r.val;
    else begin r.dst = 0; r.val = 0; end
    r.hi = hi_q;
    r.lo = lo_q;
    return r;
  endfunction

  // compare one field of the beat
  task automatic check_field(string name, int pos, int w, logic [135:0] ev, logic [135:0] av);
    logic [135:0] m;
    m = ((136'b1 << w) - 1) << pos;
    if ((ev & m) != (av & m))
      $error("%s: expected %h actual %h", name, (ev & m) >> pos, (av & m) >> pos);
    if ((ev & m) != (av & m)) errors++;
  endtask

  // acceptance on both channels
  always @(posedge clk) begin
    exec_res_t   e, t;
    logic [135:0] ev, av;
    cycle <= cycle + 1;
    if (rst_n && in_tvalid && in_tready) begin
      e = execute(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      t = typed_res_q.pop_front();
      pending_q.push_back(typed_q.pop_front() ? t : e);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no instruction outstanding");
        errors++;
      end else begin
        ev = pending_q.pop_front();
        av = out_tdata;
        check_field("reg_written", 0, 1, ev, av);
        check_field("dest_reg", 1, 5, ev, av);
        check_field("dest_value", 6, 32, ev, av);
        check_field("hi_value", 38, 32, ev, av);
        check_field("lo_value", 70, 32, ev, av);
        check_field("jump_taken", 102, 1, ev, av);
        check_field("next_pc", 103, 32, ev, av);
        check_field("divide_by_zero", 135, 1, ev, av);
      end
    end
  end

  // sink stalls, except during the quiet stretch
  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 18);

  function automatic logic [31:0] rw(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                     logic [4:0] sa);
    return {6'b0, rs, rt, rd, sa, 6'b0};
  endfunction

  task automatic send(stim_row_t row);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back(row.typed);
    typed_res_q.push_back(row.res);
    in_tvalid <= 1'b1;
    in_tuser  <= row.kind;
    in_tdata  <= {row.pc, row.iw};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic stim_row_t row_of(logic [4:0] k, logic [31:0] iw, logic [31:0] pc);
    stim_row_t s;
    s.kind = k; s.iw = iw; s.pc = pc; s.typed = 0; s.res = '0;
    return s;
  endfunction

  stim_row_t dir_tab[$];

  initial begin
    stim_row_t s;
    logic [4:0] k;
    logic [31:0] iw;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0;

    // directed table; typed rows carry the expected beat
    s = row_of(mre_pkg::K_ADD, rw(0, 0, 2, 0), 0); s.typed = 1;
    s.res = '{dz:0, npc:0, jmp:0, lo:0, hi:0, val:0, dst:2, wr:1}; dir_tab.push_back(s);
    s = row_of(mre_pkg::K_DIV, rw(3, 4, 5, 0), 0); s.typed = 1;  // divide by zero after reset
    s.res = '{dz:1, npc:0, jmp:0, lo:0, hi:0, val:0, dst:0, wr:0}; dir_tab.push_back(s);
    s = row_of(mre_pkg::K_NOR, rw(0, 0, 1, 0), 0); s.typed = 1;
    s.res = '{dz:0, npc:0, jmp:0, lo:0, hi:0, val:32'hffff_ffff, dst:1, wr:1};
    dir_tab.push_back(s);
    s = row_of(mre_pkg::K_JALR, rw(1, 0, 9, 0), 32'h7fff_fffc); s.typed = 1;
    s.res = '{dz:0, npc:32'hffff_ffff, jmp:1, lo:0, hi:0, val:32'h8000_0000, dst:31, wr:1};
    dir_tab.push_back(s);
    s = row_of(mre_pkg::K_DIV, rw(31, 1, 0, 0), 0); s.typed = 1;  // most negative by minus one
    s.res = '{dz:0, npc:0, jmp:0, lo:32'h8000_0000, hi:0, val:0, dst:0, wr:0};
    dir_tab.push_back(s);
    s = row_of(5'd27, 32'hffff_ffff, 32'hffff_ffff); s.typed = 1;  // unused kind
    s.res = '{dz:0, npc:0, jmp:0, lo:32'h8000_0000, hi:0, val:0, dst:0, wr:0};
    dir_tab.push_back(s);
    s = row_of(mre_pkg::K_ADD, rw(1, 1, 0, 0), 0); s.typed = 1;  // write to register zero dropped
    s.res = '{dz:0, npc:0, jmp:0, lo:32'h8000_0000, hi:0, val:0, dst:0, wr:0};
    dir_tab.push_back(s);
    dir_tab.push_back(row_of(mre_pkg::K_ADDU, rw(1, 31, 3, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SUB, rw(31, 1, 4, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SUBU, rw(0, 1, 5, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_MULT, rw(31, 1, 0, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_MFHI, rw(0, 0, 6, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_MULTU, rw(1, 1, 0, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_MFHI, rw(0, 0, 7, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_MFLO, rw(0, 0, 8, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_DIVU, rw(1, 31, 0, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_AND, rw(1, 31, 10, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_OR, rw(4, 31, 11, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_XOR, rw(1, 31, 12, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SLL, rw(0, 1, 13, 31), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SRL, rw(0, 1, 14, 0), 0));    // shift by zero
    dir_tab.push_back(row_of(mre_pkg::K_SRA, rw(0, 31, 15, 31), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SLLV, rw(1, 1, 16, 0), 0));   // amount from low bits of rs
    dir_tab.push_back(row_of(mre_pkg::K_SRLV, rw(1, 31, 17, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SRAV, rw(4, 31, 18, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SLT, rw(31, 1, 19, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_SLTU, rw(31, 1, 20, 0), 0));
    dir_tab.push_back(row_of(mre_pkg::K_JR, rw(31, 0, 0, 0), 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send(dir_tab[i]);

    for (int n = 0; n < 1200; n++) begin
      quiet = (n >= 400 && n < 550);
      iw = $urandom();
      // mostly legal kinds; links seed the register file with random values
      if ($urandom_range(99) < 15) k = mre_pkg::K_JALR;
      else if ($urandom_range(99) < 5) k = 5'($urandom_range(31, 24));
      else k = 5'($urandom_range(23));
      send(row_of(k, iw, $urandom()));
    end
    quiet = 0;
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0 && cycle < LIMIT) @(posedge clk);
    repeat (50) @(posedge clk);
    if (cycle >= LIMIT) $display("DONE: errors detected");
    else if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // run limit
  always @(posedge clk) begin
    if (cycle > LIMIT + 100) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/mre_pkg.sv
rtl/core/mre_ram.sv
rtl/core/mre_ctrl.sv
rtl/core/mre_dp.sv
rtl/core/mips_rtype_execute.sv
rtl/core/mre_chk.sv
dv/tb_mips_rtype_execute.sv
